// ----- hdl/dsched_pkg.sv -----
// package: shared codes and types for the disk request scheduler
`timescale 1ns / 1ps

package dsched_pkg;

    // policy register codes
    localparam logic [2:0] POL_FIFO  = 3'd0;
    localparam logic [2:0] POL_SSTF  = 3'd1;
    localparam logic [2:0] POL_LOOK  = 3'd2;
    localparam logic [2:0] POL_CLOOK = 3'd3;
    localparam logic [2:0] POL_FLOOK = 3'd4;

    // command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_PICK = 1'b1;

    // head direction codes
    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_BWD = 1'b1;

    localparam int ID_BITS = 14;

    // search kinds of the shared compare unit
    typedef enum logic [2:0] {
        KIND_AHEAD,
        KIND_BEHIND,
        KIND_NEAREST,
        KIND_LOWEST,
        KIND_FIRST
    } kind_t;

endpackage

// ----- hdl/dsched_cmp.sv -----
// shared compare unit: qualifies one entry and compares its key to the best so far
`timescale 1ns / 1ps

module dsched_cmp #(
    parameter int TRACK_BITS = 16
) (
    input  dsched_pkg::kind_t        kind,
    input  logic [TRACK_BITS-1:0]    entry_trk,
    input  logic [TRACK_BITS-1:0]    head,
    input  logic                     eligible,
    input  logic                     found,
    input  logic [TRACK_BITS-1:0]    best_key,
    output logic                     take,
    output logic [TRACK_BITS-1:0]    key
);
    import dsched_pkg::*;

    logic ok;
    logic ge;

    // qualify the entry and form its key
    always_comb
    begin
        ge  = (entry_trk >= head);
        ok  = 1'b1;
        key = '0;
        unique case (kind)
            KIND_AHEAD:
            begin
                ok  = ge;
                key = entry_trk - head;
            end
            KIND_BEHIND:
            begin
                ok  = (entry_trk <= head);
                key = head - entry_trk;
            end
            KIND_NEAREST:
            begin
                key = ge ? (entry_trk - head) : (head - entry_trk);
            end
            KIND_LOWEST:
            begin
                ok  = (entry_trk <= head);
                key = entry_trk;
            end
            default:
            begin
                key = '0;
            end
        endcase
    end

    // earliest entry wins ties, so only a strictly smaller key replaces
    assign take = eligible && ok && (!found || (key < best_key));

endmodule

// ----- hdl/disk_request_scheduler_top.sv -----
// top level: request store, sequencer and shared compare unit of the disk scheduler
//
//  channel   signals                                   direction
//  input     in_valid/in_stall, cmd req_id track head  into block
//  output    out_valid/out_stall, picked out_id ...    out of block
//  config    cfg_we, cfg_wdata (policy)                into block
//
// a pick makes one scan pass through the entry memory (twice when look, flook
// or clook turns), plus one pass to close the gap; flook adds one pass to refill
// its batch when the batch is empty. the entry memory has one read and one write port.
// reset empties the store and sets direction forward and policy fifo.
// a held result on a stalled output does not block taking the next transaction.
`timescale 1ns / 1ps

module disk_request_scheduler_top #(
    parameter int DEPTH      = 64,
    parameter int TRACK_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [dsched_pkg::ID_BITS-1:0] req_id,
    input  logic [TRACK_BITS-1:0]         track,
    input  logic [TRACK_BITS-1:0]         head_pos,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          picked,
    output logic [dsched_pkg::ID_BITS-1:0] out_id,
    output logic [TRACK_BITS-1:0]         out_track,
    output logic                          direction,
    output logic                          dropped
);
    import dsched_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = TRACK_BITS + ID_BITS + 1;
    localparam int BB = WW - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REFILL,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [2:0]             policy_reg;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          bcnt_reg;
    logic                   dir_reg;
    logic [CW-1:0]          ptr_reg;
    logic                   pend_reg;
    logic [AW-1:0]          pidx_reg;
    kind_t                  kind_reg;
    logic                   second_reg;
    logic [TRACK_BITS-1:0]  head_reg;
    logic                   found_reg;
    logic [TRACK_BITS-1:0]  best_key_reg;
    logic [AW-1:0]          best_idx_reg;
    logic [TRACK_BITS-1:0]  best_trk_reg;
    logic [ID_BITS-1:0]     best_id_reg;
    logic                   best_batch_reg;
    logic                   drop_reg;

    logic                   out_valid_reg;
    logic                   out_picked_reg;
    logic [ID_BITS-1:0]     out_id_reg;
    logic [TRACK_BITS-1:0]  out_trk_reg;
    logic                   out_dir_reg;
    logic                   out_drop_reg;

    // entry memory: {batch, id, track}
    logic [WW-1:0]          mem [DEPTH];
    logic [WW-1:0]          rdata_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [WW-1:0]          mem_wdata;
    logic                   mem_re;

    logic                   in_acc;
    logic                   full;
    logic                   pass_done;
    logic                   cmp_take;
    logic [TRACK_BITS-1:0]  cmp_key;
    logic                   eligible;
    logic                   out_free;
    logic [TRACK_BITS-1:0]  rd_trk;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign full      = (cnt_reg == CW'(DEPTH));
    assign mem_re    = ((state_reg == ST_SCAN) || (state_reg == ST_REFILL) ||
                        (state_reg == ST_SHIFT)) && (ptr_reg < cnt_reg);
    assign pass_done = !pend_reg && (ptr_reg >= cnt_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign rd_trk    = rdata_reg[TRACK_BITS-1:0];
    assign eligible  = pend_reg && ((policy_reg != POL_FLOOK) || rdata_reg[BB]);

    // memory write port select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = rdata_reg;
        priority if (state_reg == ST_IDLE)
        begin
            mem_we    = in_acc && (cmd == CMD_ADD) && !full;
            mem_waddr = cnt_reg[AW-1:0];
            mem_wdata = {1'b0, req_id, track};
        end
        else if (state_reg == ST_REFILL)
        begin
            mem_we    = pend_reg;
            mem_waddr = pidx_reg;
            mem_wdata = {1'b1, rdata_reg[BB-1:0]};
        end
        else if (state_reg == ST_SHIFT)
        begin
            mem_we    = pend_reg;
            mem_waddr = pidx_reg - AW'(1);
            mem_wdata = rdata_reg;
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    // entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    dsched_cmp #(
        .TRACK_BITS (TRACK_BITS)
    ) u_cmp (
        .kind      (kind_reg),
        .entry_trk (rd_trk),
        .head      (head_reg),
        .eligible  (eligible),
        .found     (found_reg),
        .best_key  (best_key_reg),
        .take      (cmp_take),
        .key       (cmp_key)
    );

    // sequencer, store bookkeeping and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            policy_reg     <= POL_FIFO;
            cnt_reg        <= '0;
            bcnt_reg       <= '0;
            dir_reg        <= DIR_FWD;
            ptr_reg        <= '0;
            pend_reg       <= 1'b0;
            pidx_reg       <= '0;
            kind_reg       <= KIND_FIRST;
            second_reg     <= 1'b0;
            head_reg       <= '0;
            found_reg      <= 1'b0;
            best_key_reg   <= '0;
            best_idx_reg   <= '0;
            best_trk_reg   <= '0;
            best_id_reg    <= '0;
            best_batch_reg <= 1'b0;
            drop_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_picked_reg <= 1'b0;
            out_id_reg     <= '0;
            out_trk_reg    <= '0;
            out_dir_reg    <= DIR_FWD;
            out_drop_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            // result taken and no new result loaded this cycle
            if (out_valid_reg && !out_stall && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            // read pipeline tracking
            pend_reg <= mem_re;
            pidx_reg <= ptr_reg[AW-1:0];
            if (mem_re)
            begin
                ptr_reg <= ptr_reg + CW'(1);
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        found_reg <= 1'b0;
                        drop_reg  <= (cmd == CMD_ADD) && full;
                        head_reg  <= head_pos;
                        ptr_reg   <= '0;
                        second_reg <= 1'b0;
                        if (cmd == CMD_ADD)
                        begin
                            if (!full)
                            begin
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                            state_reg <= ST_FINISH;
                        end
                        else if (cnt_reg == '0)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            unique case (policy_reg)
                                POL_SSTF:
                                begin
                                    kind_reg <= KIND_NEAREST;
                                end
                                POL_LOOK, POL_FLOOK:
                                begin
                                    kind_reg <= (dir_reg == DIR_FWD) ?
                                                KIND_AHEAD : KIND_BEHIND;
                                end
                                POL_CLOOK:
                                begin
                                    kind_reg <= KIND_AHEAD;
                                    dir_reg  <= DIR_FWD;
                                end
                                default:
                                begin
                                    kind_reg <= KIND_FIRST;
                                end
                            endcase
                            if ((policy_reg == POL_FLOOK) && (bcnt_reg == '0))
                            begin
                                state_reg <= ST_REFILL;
                            end
                            else
                            begin
                                state_reg <= ST_SCAN;
                            end
                        end
                    end
                end

                ST_REFILL:
                begin
                    // every stored entry joins the batch
                    if (pass_done)
                    begin
                        bcnt_reg  <= cnt_reg;
                        ptr_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    if (cmp_take)
                    begin
                        found_reg      <= 1'b1;
                        best_key_reg   <= cmp_key;
                        best_idx_reg   <= pidx_reg;
                        best_trk_reg   <= rd_trk;
                        best_id_reg    <= rdata_reg[BB-1:TRACK_BITS];
                        best_batch_reg <= rdata_reg[BB];
                    end
                    if (pass_done)
                    begin
                        if (found_reg)
                        begin
                            // fifo and sstf point toward the chosen track
                            if ((kind_reg == KIND_FIRST) || (kind_reg == KIND_NEAREST))
                            begin
                                if (best_trk_reg > head_reg)
                                begin
                                    dir_reg <= DIR_FWD;
                                end
                                else if (best_trk_reg < head_reg)
                                begin
                                    dir_reg <= DIR_BWD;
                                end
                            end
                            ptr_reg   <= CW'(best_idx_reg) + CW'(1);
                            state_reg <= ST_SHIFT;
                        end
                        else if (!second_reg && (policy_reg == POL_CLOOK))
                        begin
                            // wrap to the lowest track
                            second_reg <= 1'b1;
                            kind_reg   <= KIND_LOWEST;
                            dir_reg    <= DIR_BWD;
                            ptr_reg    <= '0;
                        end
                        else if (!second_reg && ((policy_reg == POL_LOOK) ||
                                                 (policy_reg == POL_FLOOK)))
                        begin
                            // nothing ahead: reverse the sweep
                            second_reg <= 1'b1;
                            kind_reg   <= (kind_reg == KIND_AHEAD) ?
                                          KIND_BEHIND : KIND_AHEAD;
                            dir_reg    <= ~dir_reg;
                            ptr_reg    <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end

                ST_SHIFT:
                begin
                    // close the gap left by the removed entry
                    if (pass_done)
                    begin
                        cnt_reg   <= cnt_reg - CW'(1);
                        bcnt_reg  <= bcnt_reg - CW'(best_batch_reg);
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_picked_reg <= found_reg;
                        out_id_reg     <= found_reg ? best_id_reg : '0;
                        out_trk_reg    <= found_reg ? best_trk_reg : '0;
                        out_dir_reg    <= dir_reg;
                        out_drop_reg   <= drop_reg;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign picked    = out_picked_reg;
    assign out_id    = out_id_reg;
    assign out_track = out_trk_reg;
    assign direction = out_dir_reg;
    assign dropped   = out_drop_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bcnt_reg <= cnt_reg)
        else $error("batch count above entry count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("accepted transaction did not start work");

    a_pick_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(picked && dropped))
        else $error("result both picked and dropped");

endmodule

// ----- verif/tb_top.sv -----
// testbench: random and directed traffic against the disk request scheduler with a predictor
`timescale 1ns / 1ps

// scoreboard: tracks the request store and checks each result transaction
class sched_scoreboard;
    logic [15:0] trk_q[$];
    logic [13:0] id_q[$];
    bit          batch_q[$];
    bit          head_dir;
    logic [2:0]  policy;
    logic [47:0] pending[$];
    int          errors;

    function new();
        head_dir = dsched_pkg::DIR_FWD;
        policy   = dsched_pkg::POL_FIFO;
        errors   = 0;
    endfunction

    // scan kinds: 0 ahead, 1 behind, 2 nearest, 3 lowest not above head
    function int find_best(int kind, logic [15:0] head, bit batch_only);
        int best;
        int unsigned best_key;
        int unsigned key;
        int unsigned t;
        best = -1;
        best_key = 0;
        for (int i = 0; i < trk_q.size(); i++) begin
            t = trk_q[i];
            if (batch_only && !batch_q[i])
                continue;
            if (kind == 0) begin
                if (t < head) continue;
                key = t - head;
            end else if (kind == 1) begin
                if (t > head) continue;
                key = head - t;
            end else if (kind == 2) begin
                key = (t >= head) ? t - head : head - t;
            end else begin
                if (t > head) continue;
                key = t;
            end
            if (best < 0 || key < best_key) begin
                best = i;
                best_key = key;
            end
        end
        return best;
    endfunction

    function int sweep_pick(logic [15:0] head, bit batch_only);
        int sel;
        if (head_dir == dsched_pkg::DIR_FWD) begin
            sel = find_best(0, head, batch_only);
            if (sel < 0) begin
                head_dir = dsched_pkg::DIR_BWD;
                sel = find_best(1, head, batch_only);
            end
        end else begin
            sel = find_best(1, head, batch_only);
            if (sel < 0) begin
                head_dir = dsched_pkg::DIR_FWD;
                sel = find_best(0, head, batch_only);
            end
        end
        return sel;
    endfunction

    function void steer(logic [15:0] t, logic [15:0] head);
        if (t > head) head_dir = dsched_pkg::DIR_FWD;
        else if (t < head) head_dir = dsched_pkg::DIR_BWD;
    endfunction

    // note an accepted input transaction and queue its expected result
    function void note_input(logic c, logic [13:0] rid, logic [15:0] trk, logic [15:0] head);
        int sel;
        bit any;
        logic        pk, dr;
        logic [13:0] oid;
        logic [15:0] otr;
        pk = 0; dr = 0; oid = 0; otr = 0;
        if (c == dsched_pkg::CMD_ADD) begin
            if (trk_q.size() >= 64) dr = 1;
            else begin
                trk_q.insert(trk_q.size(), trk);
                id_q.insert(id_q.size(), rid);
                batch_q.insert(batch_q.size(), 1'b0);
            end
        end else if (trk_q.size() > 0) begin
            case (policy)
                dsched_pkg::POL_SSTF: begin
                    sel = find_best(2, head, 0);
                    steer(trk_q[sel], head);
                end
                dsched_pkg::POL_LOOK: sel = sweep_pick(head, 0);
                dsched_pkg::POL_CLOOK: begin
                    head_dir = dsched_pkg::DIR_FWD;
                    sel = find_best(0, head, 0);
                    if (sel < 0) begin
                        head_dir = dsched_pkg::DIR_BWD;
                        sel = find_best(3, head, 0);
                    end
                end
                dsched_pkg::POL_FLOOK: begin
                    any = 0;
                    foreach (batch_q[i]) if (batch_q[i]) any = 1;
                    if (!any) foreach (batch_q[i]) batch_q[i] = 1;
                    sel = sweep_pick(head, 1);
                end
                default: begin
                    sel = 0;
                    steer(trk_q[0], head);
                end
            endcase
            if (sel >= 0) begin
                pk = 1;
                oid = id_q[sel];
                otr = trk_q[sel];
                trk_q.delete(sel);
                id_q.delete(sel);
                batch_q.delete(sel);
            end
        end
        pending.insert(pending.size(), {pk, oid, otr, head_dir, dr, 15'd0});
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(logic pk, logic [13:0] oid, logic [15:0] otr, logic d, logic dr);
        logic [47:0] e;
        if (pending.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
        end
        e = pending[0];
        pending.delete(0);
        if (pk !== e[47]) begin
            $error("picked exp %0d got %0d", e[47], pk); errors++;
        end
        if (oid !== e[46:33]) begin
            $error("out_id exp %0d got %0d", e[46:33], oid); errors++;
        end
        if (otr !== e[32:17]) begin
            $error("out_track exp %0d got %0d", e[32:17], otr); errors++;
        end
        if (d !== e[16]) begin
            $error("direction exp %0d got %0d", e[16], d); errors++;
        end
        if (dr !== e[15]) begin
            $error("dropped exp %0d got %0d", e[15], dr); errors++;
        end
    endfunction
endclass

module tb_top;
    import dsched_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [13:0] req_id;
    logic [15:0] track;
    logic [15:0] head_pos;
    logic        out_valid;
    logic        out_stall;
    logic        picked;
    logic [13:0] out_id;
    logic [15:0] out_track;
    logic        direction;
    logic        dropped;

    sched_scoreboard sb;
    bit hold_rx;
    int fill_level;

    disk_request_scheduler_top DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .req_id(req_id),
        .track(track), .head_pos(head_pos), .out_valid(out_valid),
        .out_stall(out_stall), .picked(picked), .out_id(out_id),
        .out_track(out_track), .direction(direction), .dropped(dropped)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #400ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // send one transaction, waiting for acceptance
    task automatic send(logic c, logic [13:0] rid, logic [15:0] trk, logic [15:0] head);
        in_valid <= 1;
        cmd      <= c;
        req_id   <= rid;
        track    <= trk;
        head_pos <= head;
        do @(posedge clk); while (in_stall);
        sb.note_input(c, rid, trk, head);
    endtask

    task automatic idle_input(int n);
        if (n > 0)
        begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    // wait until every expected result has arrived, then let the block settle
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_policy(logic [2:0] p);
        cfg_we    <= 1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we    <= 0;
        sb.policy = p;
    endtask

    // random track, sometimes clustered, sometimes extreme
    function automatic logic [15:0] rand_track();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        if (r < 5) return 16'($urandom_range(1000, 1040));
        return 16'($urandom);
    endfunction

    // receiver: random stall, with a long hold-off when requested
    initial
    begin
        int n;
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_rx)
            begin
                out_stall <= 1;
                repeat (2000) @(posedge clk);
                hold_rx = 0;
            end
            else
            begin
                n = gap_len();
                out_stall <= (n > 0);
                repeat (n > 0 ? n : 1) @(posedge clk);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(picked, out_id, out_track, direction, dropped);
    end

    // stimulus
    initial
    begin
        sb = new();
        rst_n = 0; cfg_we = 0; cfg_wdata = 0; in_valid = 0;
        cmd = 0; req_id = 0; track = 0; head_pos = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty pick, extremes, ties, fifo, sstf, clook and policy code 7
        send(CMD_PICK, 14'h3FFF, 16'hFFFF, 16'hFFFF);
        send(CMD_ADD, 14'h0000, 16'h0000, 16'h0000);
        send(CMD_ADD, 14'h3FFF, 16'hFFFF, 16'h0000);
        send(CMD_ADD, 14'h1555, 16'h8000, 16'h0000);
        send(CMD_ADD, 14'h2AAA, 16'h8000, 16'h0000);
        send(CMD_PICK, 14'd0, 16'd0, 16'h8000);
        drain();
        set_policy(POL_SSTF);
        send(CMD_PICK, 14'd0, 16'd0, 16'h7FFF);
        send(CMD_PICK, 14'd0, 16'd0, 16'h0000);
        send(CMD_ADD, 14'h0101, 16'h0010, 16'd0);
        send(CMD_ADD, 14'h0202, 16'h0030, 16'd0);
        send(CMD_PICK, 14'd0, 16'd0, 16'h0020);
        drain();
        set_policy(POL_CLOOK);
        send(CMD_PICK, 14'd0, 16'd0, 16'hFFFF);
        send(CMD_ADD, 14'h0303, 16'h0005, 16'd0);
        send(CMD_PICK, 14'd0, 16'd0, 16'h0001);
        drain();
        set_policy(3'd7);
        send(CMD_PICK, 14'd0, 16'd0, 16'h0000);
        send(CMD_PICK, 14'd0, 16'd0, 16'h0000);
        drain();

        // fill the store past full under a long receiver hold-off
        hold_rx = 1;
        for (int i = 0; i < 66; i++)
            send(CMD_ADD, 14'($urandom), rand_track(), 16'($urandom));
        drain();

        // random phases across all policies, extremes included
        for (int ph = 0; ph < 12; ph++)
        begin
            logic [2:0] p;
            p = (ph < 5) ? ph[2:0] : ((ph == 11) ? 3'd7 : 3'($urandom_range(0, 7)));
            set_policy(p);
            for (int i = 0; i < 55; i++)
            begin
                fill_level = sb.trk_q.size();
                if ($urandom_range(0, 99) < (fill_level < 4 ? 75 : (fill_level > 40 ? 25 : 50)))
                    send(CMD_ADD, 14'($urandom), rand_track(), 16'($urandom));
                else
                    send(CMD_PICK, 14'($urandom), 16'($urandom), rand_track());
                idle_input(gap_len());
            end
            drain();
        end

        in_valid <= 0;
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
